FILE: rtl/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types and constants for the 16.16 affine transform composer.
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int W         = 32;
    localparam int FRAC_BITS = 16;
    localparam int N_A       = 6;
    localparam int N_B       = 4;
    localparam int N_PROD    = 12;
    localparam int N_OUT     = 6;

    // operand slots of the first transform
    localparam logic [2:0] A_XX = 3'd0;
    localparam logic [2:0] A_XY = 3'd1;
    localparam logic [2:0] A_YX = 3'd2;
    localparam logic [2:0] A_YY = 3'd3;
    localparam logic [2:0] A_DX = 3'd4;
    localparam logic [2:0] A_DY = 3'd5;

    // operand slots of the second transform's matrix
    localparam logic [1:0] B_XX = 2'd0;
    localparam logic [1:0] B_XY = 2'd1;
    localparam logic [1:0] B_YX = 2'd2;
    localparam logic [1:0] B_YY = 2'd3;

    // output j sums products 2j and 2j+1
    localparam logic [2:0] PROD_A [N_PROD] = '{
        A_XX, A_YX, A_XY, A_YY, A_DX, A_DY,
        A_XX, A_YX, A_XY, A_YY, A_DX, A_DY
    };
    localparam logic [1:0] PROD_B [N_PROD] = '{
        B_XX, B_XY, B_XX, B_XY, B_XX, B_XY,
        B_YX, B_YY, B_YX, B_YY, B_YX, B_YY
    };

    typedef struct packed {
        logic signed [W-1:0] a_xx;
        logic signed [W-1:0] a_xy;
        logic signed [W-1:0] a_yx;
        logic signed [W-1:0] a_yy;
        logic signed [W-1:0] a_dx;
        logic signed [W-1:0] a_dy;
        logic signed [W-1:0] b_xx;
        logic signed [W-1:0] b_xy;
        logic signed [W-1:0] b_yx;
        logic signed [W-1:0] b_yy;
        logic signed [W-1:0] b_dx;
        logic signed [W-1:0] b_dy;
    } t_in_word;

    typedef struct packed {
        logic signed [W-1:0] out_xx;
        logic signed [W-1:0] out_xy;
        logic signed [W-1:0] out_dx;
        logic signed [W-1:0] out_yx;
        logic signed [W-1:0] out_yy;
        logic signed [W-1:0] out_dy;
    } t_out_word;

    typedef struct packed {
        logic [N_A-1:0][W-1:0] a_mag;
        logic [N_A-1:0]        a_neg;
        logic [N_B-1:0][W-1:0] b_mag;
        logic [N_B-1:0]        b_neg;
        logic [W-1:0]          b_dx;
        logic [W-1:0]          b_dy;
    } t_mag_word;

    typedef struct packed {
        logic [N_PROD-1:0][W-1:0] prod;
        logic [N_PROD-1:0]        neg;
        logic [W-1:0]             b_dx;
        logic [W-1:0]             b_dy;
    } t_prod_word;

endpackage

FILE: rtl/acf_mag.sv
// ----------------------------------------------------------------------------
// acf_mag
// Magnitude stage: split every operand but the second transform's offsets into sign and magnitude.
// ----------------------------------------------------------------------------
module acf_mag (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  acf_pkg::t_in_word i_data,
    output logic              o_ready,
    output logic              o_valid,
    output acf_pkg::t_mag_word o_data,
    input  logic              i_ready
);

    function automatic logic [acf_pkg::W-1:0] mag_of(input logic [acf_pkg::W-1:0] x);
        return x[acf_pkg::W-1] ? (~x + 1'b1) : x;
    endfunction

    logic               r_valid;
    acf_pkg::t_mag_word r_data;
    acf_pkg::t_mag_word n_data;

    always_comb begin
        n_data = '0;
        n_data.a_mag[acf_pkg::A_XX] = mag_of(i_data.a_xx);
        n_data.a_mag[acf_pkg::A_XY] = mag_of(i_data.a_xy);
        n_data.a_mag[acf_pkg::A_YX] = mag_of(i_data.a_yx);
        n_data.a_mag[acf_pkg::A_YY] = mag_of(i_data.a_yy);
        n_data.a_mag[acf_pkg::A_DX] = mag_of(i_data.a_dx);
        n_data.a_mag[acf_pkg::A_DY] = mag_of(i_data.a_dy);
        n_data.a_neg[acf_pkg::A_XX] = i_data.a_xx[acf_pkg::W-1];
        n_data.a_neg[acf_pkg::A_XY] = i_data.a_xy[acf_pkg::W-1];
        n_data.a_neg[acf_pkg::A_YX] = i_data.a_yx[acf_pkg::W-1];
        n_data.a_neg[acf_pkg::A_YY] = i_data.a_yy[acf_pkg::W-1];
        n_data.a_neg[acf_pkg::A_DX] = i_data.a_dx[acf_pkg::W-1];
        n_data.a_neg[acf_pkg::A_DY] = i_data.a_dy[acf_pkg::W-1];
        n_data.b_mag[acf_pkg::B_XX] = mag_of(i_data.b_xx);
        n_data.b_mag[acf_pkg::B_XY] = mag_of(i_data.b_xy);
        n_data.b_mag[acf_pkg::B_YX] = mag_of(i_data.b_yx);
        n_data.b_mag[acf_pkg::B_YY] = mag_of(i_data.b_yy);
        n_data.b_neg[acf_pkg::B_XX] = i_data.b_xx[acf_pkg::W-1];
        n_data.b_neg[acf_pkg::B_XY] = i_data.b_xy[acf_pkg::W-1];
        n_data.b_neg[acf_pkg::B_YX] = i_data.b_yx[acf_pkg::W-1];
        n_data.b_neg[acf_pkg::B_YY] = i_data.b_yy[acf_pkg::W-1];
        n_data.b_dx = i_data.b_dx;
        n_data.b_dy = i_data.b_dy;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/acf_mul.sv
// ----------------------------------------------------------------------------
// acf_mul
// Product stage: twelve magnitude multiplies, fraction bits dropped.
// ----------------------------------------------------------------------------
module acf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  acf_pkg::t_mag_word  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output acf_pkg::t_prod_word o_data,
    input  logic                i_ready
);

    logic                [2*acf_pkg::W-1:0] w_full [acf_pkg::N_PROD];
    logic                r_valid;
    acf_pkg::t_prod_word r_data;
    acf_pkg::t_prod_word n_data;

    always_comb begin
        n_data = '0;
        for (int k = 0; k < acf_pkg::N_PROD; k++) begin
            w_full[k] = {{acf_pkg::W{1'b0}}, i_data.a_mag[acf_pkg::PROD_A[k]]}
                      * {{acf_pkg::W{1'b0}}, i_data.b_mag[acf_pkg::PROD_B[k]]};
            // keep the 32 bits above the fraction, the rest wraps away
            n_data.prod[k] = w_full[k][acf_pkg::FRAC_BITS +: acf_pkg::W];
            n_data.neg[k]  = i_data.a_neg[acf_pkg::PROD_A[k]]
                           ^ i_data.b_neg[acf_pkg::PROD_B[k]];
        end
        n_data.b_dx = i_data.b_dx;
        n_data.b_dy = i_data.b_dy;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/acf_sum.sv
// ----------------------------------------------------------------------------
// acf_sum
// Sum stage: apply product signs, add pairs and offsets into the result.
// ----------------------------------------------------------------------------
module acf_sum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  acf_pkg::t_prod_word i_data,
    output logic                o_ready,
    output logic                o_valid,
    output acf_pkg::t_out_word  o_data,
    input  logic                i_ready
);

    logic [acf_pkg::W-1:0] w_term [acf_pkg::N_PROD];
    logic                  r_valid;
    acf_pkg::t_out_word    r_data;
    acf_pkg::t_out_word    n_data;

    always_comb begin
        for (int k = 0; k < acf_pkg::N_PROD; k++) begin
            // zero magnitude negates to zero, so no special handling
            w_term[k] = i_data.neg[k] ? (~i_data.prod[k] + 1'b1) : i_data.prod[k];
        end
        n_data.out_xx = w_term[0]  + w_term[1];
        n_data.out_xy = w_term[2]  + w_term[3];
        n_data.out_dx = w_term[4]  + w_term[5]  + i_data.b_dx;
        n_data.out_yx = w_term[6]  + w_term[7];
        n_data.out_yy = w_term[8]  + w_term[9];
        n_data.out_dy = w_term[10] + w_term[11] + i_data.b_dy;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/affine_compose_fixed16.sv
// ----------------------------------------------------------------------------
// affine_compose_fixed16
// Composes two 2D affine transforms in signed 16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  channel  | signals                  | word
//  ---------+--------------------------+-----------------------------------
//  in       | i_valid, o_ready, i_in   | t_in_word: both transforms, 12 terms
//  out      | o_valid, i_ready, o_out  | t_out_word: composed transform
//
//  One word enters per cycle and one result leaves per cycle when the sink
//  keeps i_ready high. A word passes through four register stages in order:
//  input (loaded at acceptance), magnitude, the twelve 32x32 multipliers, and
//  the signed sum into the result. Reset clears only the stage valid flags;
//  payload registers are left as is. A stall at the sink fills bubbles first,
//  then holds every stage in place; o_ready falls only once all four stages
//  hold a word.
//
module affine_compose_fixed16 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  acf_pkg::t_in_word  i_in,
    output logic               o_ready,
    output logic               o_valid,
    output acf_pkg::t_out_word o_out,
    input  logic               i_ready
);

    // input register: hold the accepted word for the magnitude stage
    logic              r_in_valid;
    acf_pkg::t_in_word r_in;
    logic              w_mag_ready;

    assign o_ready = !r_in_valid || w_mag_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
    end

    // magnitude stage
    logic               w_mag_valid;
    acf_pkg::t_mag_word w_mag;
    logic               w_mul_ready;

    acf_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_data  (r_in),
        .o_ready (w_mag_ready),
        .o_valid (w_mag_valid),
        .o_data  (w_mag),
        .i_ready (w_mul_ready)
    );

    // product stage
    logic                w_mul_valid;
    acf_pkg::t_prod_word w_prod;
    logic                w_sum_ready;

    acf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mag_valid),
        .i_data  (w_mag),
        .o_ready (w_mul_ready),
        .o_valid (w_mul_valid),
        .o_data  (w_prod),
        .i_ready (w_sum_ready)
    );

    // sum stage drives the result register straight onto the output port
    acf_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .i_data  (w_prod),
        .o_ready (w_sum_ready),
        .o_valid (o_valid),
        .o_data  (o_out),
        .i_ready (i_ready)
    );

    // words in flight, for checking only
    logic [2:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= r_fill + {2'b00, (i_valid && o_ready)}
                             - {2'b00, (o_valid && i_ready)};
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_fill != 3'd0)
        else $error("result offered with no word in flight");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 3'd4 && !i_ready) |-> !o_ready)
        else $error("input taken while every stage is full and stalled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 3'd0) |=> (!o_valid))
        else $error("result appeared one cycle after an empty pipeline");

endmodule
